FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define RSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("randomized set engine assertion failed");

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define RSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("randomized set engine assertion failed");

`endif

FILE: rtl/rse_pkg.sv
// Package with the field widths, action codes and status codes of the set engine.
`default_nettype none
package rse_pkg;

  localparam int ACT_W        = 2;
  localparam int VAL_W        = 32;
  localparam int RND_W        = 31;
  localparam int RND_CNT_W    = $clog2(RND_W);
  localparam int ST_W         = 3;
  localparam int CAPACITY_DEF = 64;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [VAL_W-1:0] value_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_PICK   = 2'd2;
  localparam action_t ACT_NOP    = 2'd3;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_PRESENT = 3'd1;
  localparam status_t ST_ABSENT  = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_EMPTY   = 3'd4;

endpackage
`default_nettype wire

FILE: rtl/rse_cell.sv
// One cell of the entry ring: holds one 32-bit entry and passes it on when the ring turns.
`default_nettype none
module rse_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire rse_pkg::value_t shift_in,
  output rse_pkg::value_t      value
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= shift_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rse_div.sv
// Restoring remainder unit: random word modulo the live count, one quotient bit per cycle.
`default_nettype none
module rse_div #(
  parameter int CW = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rse_pkg::RND_W-1:0] dividend,
  input  wire logic [CW-1:0]             divisor,
  output logic                           done,
  output logic [CW-1:0]                  remainder
);

  logic                          run;
  logic [rse_pkg::RND_CNT_W-1:0] cnt;
  logic [rse_pkg::RND_W-1:0]     dvd;
  logic [CW-1:0]                 dsr;
  logic [CW:0]                   trial;
  logic [CW:0]                   diff;

  // Bring down the next dividend bit and subtract when the divisor fits.
  assign trial = {remainder, dvd[rse_pkg::RND_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == rse_pkg::RND_CNT_W'(rse_pkg::RND_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (run) begin
      dvd <= {dvd[rse_pkg::RND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        remainder <= diff[CW-1:0];
      end else begin
        remainder <= trial[CW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/randomized_set_engine_core.sv
// Randomized set engine: a ring of entry cells with insert, remove and random pick.
//
// A command is transferred at a rising edge where start is high and busy is low:
// action, item_value and random_word are sampled there. Exactly one result follows,
// shown on status, picked_value and live_count for the single cycle in which done
// is high; the receiver cannot hold it off. For an insert, a remove or a pick on a
// non-empty set busy is high from the cycle after the transfer until the cycle in which
// done rises, and a new command may be given in that cycle; a no-op or a pick on an empty
// set never raises busy. The entries live in a ring of CAPACITY cells that turns once per
// pass; the head cell is compared against the item at each step of the pass.
// An insert, or a remove of an absent value, runs one pass. A remove of a present value
// runs a second pass that moves the last entry into the freed slot. A pick first runs
// the remainder unit, one bit per cycle, and then one pass that reads the chosen entry.
// A no-op, or a pick on an empty set, answers without a pass.
// One command is in flight at a time.
// Reset empties the set; entry contents are not cleared and need no clearing pass.
`default_nettype none
module randomized_set_engine_core #(
  parameter int CAPACITY = rse_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rse_pkg::ACT_W-1:0]   action,
  input  wire logic signed [rse_pkg::VAL_W-1:0] item_value,
  input  wire logic [rse_pkg::RND_W-1:0]   random_word,
  output logic                             done,
  output logic [rse_pkg::ST_W-1:0]         status,
  output logic signed [rse_pkg::VAL_W-1:0] picked_value,
  output logic [CW-1:0]                    live_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIX  = 2'd3;

  logic [1:0]             state, state_next;
  logic [IW-1:0]          k, k_next;
  logic                   found, found_next;
  logic [IW-1:0]          pos, pos_next;
  rse_pkg::value_t        last, last_next;
  rse_pkg::action_t       act, act_next;
  rse_pkg::value_t        item, item_next;
  logic [CW-1:0]          count, count_next;
  rse_pkg::status_t       status_q, status_next;
  rse_pkg::value_t        picked, picked_next;
  logic                   done_next;

  rse_pkg::value_t        cell_q [CAPACITY];
  rse_pkg::value_t        head;
  rse_pkg::value_t        tail_in;
  logic                   shift_en;
  logic [CW-1:0]          k_ext;
  logic                   live, match, found_now, last_step, accept, div_start;
  logic [IW-1:0]          pos_now;
  logic                   div_done;
  logic [CW-1:0]          div_rem;

  // The ring: each cell takes its upper neighbor; the top cell takes the tail input.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == CAPACITY - 1) begin : g_tail
      rse_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .shift_in (tail_in),
        .value    (cell_q[gi])
      );
    end else begin : g_body
      rse_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .shift_in (cell_q[gi+1]),
        .value    (cell_q[gi])
      );
    end
  end

  rse_div #(.CW(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_word),
    .divisor   (count),
    .done      (div_done),
    .remainder (div_rem)
  );

  // After k turns of the ring, the head cell holds entry k.
  assign head      = cell_q[0];
  assign k_ext     = CW'(k);
  assign live      = (k_ext < count);
  assign last_step = (k == IW'(CAPACITY - 1));
  assign match     = (state == S_SCAN) && live && (head == item) &&
                     ((act == rse_pkg::ACT_INSERT) || (act == rse_pkg::ACT_REMOVE));
  assign found_now = found || match;
  assign pos_now   = found ? pos : k;
  assign shift_en  = (state == S_SCAN) || (state == S_FIX);
  assign accept    = start && !busy;
  assign div_start = accept && (action == rse_pkg::ACT_PICK) && (count != '0);

  always_comb begin
    tail_in = head;
    if ((state == S_SCAN) && (act == rse_pkg::ACT_INSERT) && (k_ext == count) && !found) begin
      tail_in = item;
    end else if ((state == S_FIX) && (k == pos)) begin
      tail_in = last;
    end
  end

  always_comb begin
    state_next  = state;
    k_next      = k;
    found_next  = found;
    pos_next    = pos;
    last_next   = last;
    act_next    = act;
    item_next   = item;
    count_next  = count;
    status_next = status_q;
    picked_next = picked;
    done_next   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          act_next    = action;
          item_next   = $unsigned(item_value);
          found_next  = 1'b0;
          k_next      = '0;
          picked_next = '0;
          status_next = rse_pkg::ST_OK;
          unique case (action) inside
            rse_pkg::ACT_INSERT, rse_pkg::ACT_REMOVE: begin
              state_next = S_SCAN;
            end
            rse_pkg::ACT_PICK: begin
              if (count == '0) begin
                status_next = rse_pkg::ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                state_next = S_DIV;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          // The remainder is below the count, so it fits an index.
          pos_next   = div_rem[IW-1:0];
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        k_next = k + 1'b1;
        if (match && !found) begin
          found_next = 1'b1;
          pos_next   = k;
        end
        if ((act == rse_pkg::ACT_REMOVE) && (count == k_ext + CW'(1))) begin
          last_next = head;
        end
        if ((act == rse_pkg::ACT_PICK) && (k == pos)) begin
          picked_next = head;
        end
        if (last_step) begin
          k_next = '0;
          case (act)
            rse_pkg::ACT_INSERT: begin
              state_next = S_IDLE;
              done_next  = 1'b1;
              if (found_now) begin
                status_next = rse_pkg::ST_PRESENT;
              end else if (count == CW'(CAPACITY)) begin
                status_next = rse_pkg::ST_FULL;
              end else begin
                count_next = count + 1'b1;
              end
            end
            rse_pkg::ACT_REMOVE: begin
              if (found_now) begin
                pos_next   = pos_now;
                state_next = S_FIX;
              end else begin
                status_next = rse_pkg::ST_ABSENT;
                state_next  = S_IDLE;
                done_next   = 1'b1;
              end
            end
            default: begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end
          endcase
        end
      end

      S_FIX: begin
        k_next = k + 1'b1;
        if (last_step) begin
          k_next     = '0;
          count_next = count - 1'b1;
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      k     <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      k     <= k_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    last     <= last_next;
    act      <= act_next;
    item     <= item_next;
    status_q <= status_next;
    picked   <= picked_next;
  end

  assign busy         = (state != S_IDLE);
  assign status       = status_q;
  assign picked_value = $signed(picked);
  assign live_count   = count;

endmodule
`default_nettype wire

FILE: rtl/rse_checker.sv
// Port-level checker for the set engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rse_checker #(
  parameter int CAPACITY = rse_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [rse_pkg::ACT_W-1:0]   action,
  input wire logic                        done,
  input wire logic [rse_pkg::ST_W-1:0]    status,
  input wire logic signed [rse_pkg::VAL_W-1:0] picked_value,
  input wire logic [CW-1:0]               live_count
);

  // A no-op command answers in the very next cycle with success.
  `RSE_ASSERT_NXT(a_nop_answer, start && !busy && (action == rse_pkg::ACT_NOP), done && (status == rse_pkg::ST_OK) && (picked_value == '0))

  // Any result that is not a success carries no picked entry.
  `RSE_ASSERT_IMP(a_fail_no_pick, done && (status != rse_pkg::ST_OK), picked_value == '0)

  // A full report only comes with a full store, and the count never exceeds it.
  `RSE_ASSERT_IMP(a_full_count, done && (status == rse_pkg::ST_FULL), live_count == CW'(CAPACITY))

  `RSE_ASSERT_IMP(a_count_bound, done, live_count <= CW'(CAPACITY))

  // An empty report only comes with an empty set.
  `RSE_ASSERT_IMP(a_empty_count, done && (status == rse_pkg::ST_EMPTY), live_count == '0)

endmodule

bind randomized_set_engine_core rse_checker #(.CAPACITY(CAPACITY)) u_rse_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .status       (status),
  .picked_value (picked_value),
  .live_count   (live_count)
);
`default_nettype wire
